// ===== hw/rtl/cc20_pkg.sv =====
// Shared types and constants for the ChaCha20 stream cipher block.
package cc20_pkg;

	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DOUBLE_ROUNDS = 10;

	localparam logic [31:0] SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	localparam logic [2:0] REG_KEY_PART_0 = 3'd0;
	localparam logic [2:0] REG_KEY_PART_1 = 3'd1;
	localparam logic [2:0] REG_KEY_PART_2 = 3'd2;
	localparam logic [2:0] REG_KEY_PART_3 = 3'd3;
	localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [2:0] REG_NONCE_HIGH = 3'd5;

	typedef struct packed {
		logic [7:0] data_in;
		logic       last_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} out_item_t;

	typedef struct packed {
		logic [31:0] nonce_high;
		logic [63:0] nonce_low;
		logic [63:0] key_part_3;
		logic [63:0] key_part_2;
		logic [63:0] key_part_1;
		logic [63:0] key_part_0;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic blk_ready;
		logic last_step;
		logic out_free;
	} stat_t;

endpackage

// ===== hw/rtl/cc20_ctrl.sv =====
// Sequencer for the ChaCha20 block: request capture, block build, byte emit.
module cc20_ctrl import cc20_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_INIT   = 5'b00010,
		S_ROUND  = 5'b00100,
		S_FINAL  = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.blk_ready ? S_EMIT : S_INIT;
				end
			end
			S_INIT: begin
				cmd.load = 1'b1;
				state_d  = S_ROUND;
			end
			S_ROUND: begin
				cmd.step = 1'b1;
				if (stat.last_step) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/cc20_dpath.sv =====
// ChaCha20 datapath: working state, quarter-round unit, keystream byte XOR.
module cc20_dpath import cc20_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	input  logic      out_ready,
	output stat_t     stat,
	output logic      out_valid,
	output out_item_t out_item
);

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_t;

	function automatic qr_t qr_mix(input qr_t v);
		qr_t r;
		r = v;
		r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[15:0], r.d[31:16]};
		r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[19:0], r.b[31:20]};
		r.a = r.a + r.b; r.d = r.d ^ r.a; r.d = {r.d[23:0], r.d[31:24]};
		r.c = r.c + r.d; r.b = r.b ^ r.c; r.b = {r.b[24:0], r.b[31:25]};
		return r;
	endfunction

	// Working state doubles as the keystream block once the final add is done.
	logic [31:0] x_q [16];
	logic [31:0] init_w [16];
	logic [31:0] nxt_w [16];
	logic [31:0] col_new [4];

	logic [2:0]  step_q;
	logic [3:0]  dround_q;
	logic [5:0]  pos_q;
	logic [31:0] ctr_q;
	logic        ready_q;
	logic [7:0]  hold_data_q;
	logic        hold_last_q;
	logic        out_valid_q;
	out_item_t   out_q;

	qr_t         qr_in, qr_out;
	logic        end_col, end_diag;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i] = SIGMA[i];
		end
		init_w[4]  = cfg.key_part_0[31:0];
		init_w[5]  = cfg.key_part_0[63:32];
		init_w[6]  = cfg.key_part_1[31:0];
		init_w[7]  = cfg.key_part_1[63:32];
		init_w[8]  = cfg.key_part_2[31:0];
		init_w[9]  = cfg.key_part_2[63:32];
		init_w[10] = cfg.key_part_3[31:0];
		init_w[11] = cfg.key_part_3[63:32];
		init_w[12] = ctr_q;
		init_w[13] = cfg.nonce_low[31:0];
		init_w[14] = cfg.nonce_low[63:32];
		init_w[15] = cfg.nonce_high;
	end

	// The quarter round always works on column 0; rows rotate after each step
	// so the next column or diagonal lands there.
	assign qr_in    = '{a: x_q[0], b: x_q[4], c: x_q[8], d: x_q[12]};
	assign qr_out   = qr_mix(qr_in);
	assign end_col  = (step_q == 3'd3);
	assign end_diag = (step_q == 3'd7);

	assign col_new[0] = qr_out.a;
	assign col_new[1] = qr_out.b;
	assign col_new[2] = qr_out.c;
	assign col_new[3] = qr_out.d;

	always_comb begin
		logic [31:0] t [4];
		logic [1:0]  rr;
		logic [1:0]  sh;
		for (int r = 0; r < 4; r++) begin
			t[0] = col_new[r];
			t[1] = x_q[4*r+1];
			t[2] = x_q[4*r+2];
			t[3] = x_q[4*r+3];
			rr   = 2'(r);
			if (end_col) begin
				sh = 2'd1 + rr;
			end else if (end_diag) begin
				sh = 2'd1 - rr;
			end else begin
				sh = 2'd1;
			end
			for (int c = 0; c < 4; c++) begin
				nxt_w[4*r+c] = t[2'(2'(c) + sh)];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			if (cmd.load) begin
				x_q[i] <= init_w[i];
			end else if (cmd.step) begin
				x_q[i] <= nxt_w[i];
			end else if (cmd.finish) begin
				x_q[i] <= x_q[i] + init_w[i];
			end
		end
		if (cmd.accept) begin
			hold_data_q <= in_item.data_in;
			hold_last_q <= in_item.last_in;
		end
		if (cmd.emit) begin
			out_q.data_out <= hold_data_q ^ ks_byte;
			out_q.last_out <= hold_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			dround_q <= '0;
		end else if (cmd.load) begin
			step_q   <= '0;
			dround_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_q + 3'd1;
			if (end_diag) begin
				dround_q <= dround_q + 4'd1;
			end
		end
	end

	assign ks_word = x_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ctr_q   <= '0;
			ready_q <= 1'b0;
		end else if (cmd.finish) begin
			ready_q <= 1'b1;
		end else if (cmd.emit) begin
			if (hold_last_q) begin
				pos_q   <= '0;
				ctr_q   <= '0;
				ready_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					ctr_q   <= ctr_q + 32'd1;
					ready_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.blk_ready = ready_q;
	assign stat.last_step = end_diag && (dround_q == 4'(DOUBLE_ROUNDS - 1));
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_item       = out_q;

endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// Top level of the ChaCha20 stream cipher: register port and block wiring.
//
// Feed one message byte per request on the in_* channel; each byte comes back
// on the out_* channel XORed with the next ChaCha20 keystream byte, with its
// last flag copied. A byte marked last ends the message: the next byte starts
// a new message at block counter 0, byte 0.
// Key and nonce sit in six APB registers at byte addresses 8*i; write them
// only while no request is in flight. A new key takes effect at the next block.
// Byte flow: a byte inside a ready keystream block is accepted in the idle
// state and XORed into the output register by the emit state once that
// register is free; only then is the next request taken. The first byte of
// every 64-byte block also waits for the block build: a load step, 10 double
// rounds on the single quarter-round unit (one quarter round per cycle) and
// a final add, before it goes to the output register. The quarter-round
// unit sets the average byte rate of the block.
// Reset clears the sequencer, block counter, byte position and registers; the
// first byte after reset builds block 0. When the receiver stalls, the output
// register holds its request; the block takes one more byte and then holds
// in_ready low until the output register drains.
module chacha20_stream_cipher import cc20_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// message byte channel
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	// result byte channel
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	cfg_t       cfg_q;
	cmd_t       cmd;
	stat_t      stat;
	logic       wr_en;
	logic [2:0] reg_idx;

	// Registers are 64 bits wide, so each one takes an 8-byte slot.
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Capture register writes; addresses past the last register drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KEY_PART_0: cfg_q.key_part_0 <= pwdata;
				REG_KEY_PART_1: cfg_q.key_part_1 <= pwdata;
				REG_KEY_PART_2: cfg_q.key_part_2 <= pwdata;
				REG_KEY_PART_3: cfg_q.key_part_3 <= pwdata;
				REG_NONCE_LOW:  cfg_q.nonce_low  <= pwdata;
				REG_NONCE_HIGH: cfg_q.nonce_high <= pwdata[31:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the stored value; the high word of the nonce register reads 0.
	always_comb begin
		case (reg_idx)
			REG_KEY_PART_0: prdata = cfg_q.key_part_0;
			REG_KEY_PART_1: prdata = cfg_q.key_part_1;
			REG_KEY_PART_2: prdata = cfg_q.key_part_2;
			REG_KEY_PART_3: prdata = cfg_q.key_part_3;
			REG_NONCE_LOW:  prdata = cfg_q.nonce_low;
			REG_NONCE_HIGH: prdata = {32'd0, cfg_q.nonce_high};
			default:        prdata = '0;
		endcase
	end

	// Sequencer: takes a request, builds a block when the current one is
	// used up, then hands the byte to the output register.
	cc20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Datapath: working state, quarter-round unit, byte position and counter.
	cc20_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_item   (in_item),
		.cmd       (cmd),
		.out_ready (out_ready),
		.stat      (stat),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule
